>>> hw/rtl/c3n_pkg.sv
`timescale 1ns / 1ps

package c3n_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;
    localparam int WIN_DIM    = 3;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WID_W = COL_W + 1;
    localparam int HGT_W = ROW_W + 1;

    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;
    localparam int TAPS   = WIN_DIM * WIN_DIM;
    localparam int TAP_W  = $clog2(TAPS);

    localparam int PROD_W = 2 * CH_W + 1;
    localparam int ACC_W  = 20;
    localparam int DIV_W  = 12;
    localparam int REM_W  = ACC_W - 1;
    localparam int Q_W    = CH_W;
    localparam int STEP_W = $clog2(Q_W);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int KROW_W     = CH_W * WIN_DIM;

    localparam logic [WID_W-1:0]  WIDTH_RST  = WID_W'(640);
    localparam logic [HGT_W-1:0]  HEIGHT_RST = HGT_W'(480);
    localparam logic [KROW_W-1:0] KTOP_RST   = KROW_W'(24'h010201);
    localparam logic [KROW_W-1:0] KMID_RST   = KROW_W'(24'h020402);
    localparam logic [KROW_W-1:0] KBOT_RST   = KROW_W'(24'h010201);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_KTOP   = 3'd2,
        REG_KMID   = 3'd3,
        REG_KBOT   = 3'd4
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] rgb_t;
    typedef logic signed [CH_W-1:0] coef_t;

    typedef struct packed {
        rgb_t [TAPS-1:0] win;
        logic            last;
    } job_t;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
        logic             restart;
    } geom_t;

    typedef struct packed {
        coef_t [TAPS-1:0]        coef;
        logic signed [DIV_W-1:0] divisor;
    } kern_t;

    typedef enum logic {
        F_IDLE,
        F_LOAD
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAC,
        B_SETUP,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

>>> hw/rtl/c3n_if.sv
`timescale 1ns / 1ps

interface c3n_pix_if;
    logic                      valid;
    logic                      ready;
    logic [c3n_pkg::CH_W-1:0]  red;
    logic [c3n_pkg::CH_W-1:0]  green;
    logic [c3n_pkg::CH_W-1:0]  blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface c3n_res_if;
    logic                      valid;
    logic                      ready;
    logic [c3n_pkg::CH_W-1:0]  out_red;
    logic [c3n_pkg::CH_W-1:0]  out_green;
    logic [c3n_pkg::CH_W-1:0]  out_blue;
    logic                      frame_last;

    modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

interface c3n_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [c3n_pkg::CFG_IDX_W-1:0]   index;
    logic [c3n_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/conv3x3_rgb_normalized.sv
`timescale 1ns / 1ps

// channel      role    payload                                 transaction
// pixel_in     sink    red, green, blue                        valid && ready
// result_out   source  out_red, out_green, out_blue, frame_last valid && ready
// cfg          sink    index, data                             valid && ready (ready tied high)
//
// Front: line store read, then window shift and store write; one pixel at a time.
// Back: per interior pixel, 9-tap serial MAC, setup, 8-step divider, hand-off.
// Border pixels occupy only the front; a 2-entry queue decouples the two.
// Reset: front and queue counters, window cleared; line stores hold no reset value.
// A stalled result_out holds its register; the front runs on until the queue fills.

module conv3x3_rgb_normalized (
    input  logic      clk,
    input  logic      rst_n,
    c3n_pix_if.sink   pixel_in,
    c3n_res_if.source result_out,
    c3n_cfg_if.sink   cfg
);

    logic [c3n_pkg::WID_W-1:0]  width_reg;
    logic [c3n_pkg::HGT_W-1:0]  height_reg;
    logic [c3n_pkg::KROW_W-1:0] ktop_reg;
    logic [c3n_pkg::KROW_W-1:0] kmid_reg;
    logic [c3n_pkg::KROW_W-1:0] kbot_reg;

    c3n_pkg::geom_t geom;
    c3n_pkg::kern_t kern;
    c3n_pkg::job_t  q_in;
    c3n_pkg::job_t  q_out;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    logic           cfg_we;
    logic signed [c3n_pkg::DIV_W-1:0] dsum;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    always_comb
    begin
        geom.width = (width_reg < c3n_pkg::WID_W'(c3n_pkg::MIN_DIM))
                   ? c3n_pkg::WID_W'(c3n_pkg::MIN_DIM)
                   : (width_reg > c3n_pkg::WID_W'(c3n_pkg::MAX_WIDTH))
                   ? c3n_pkg::WID_W'(c3n_pkg::MAX_WIDTH) : width_reg;
        geom.height = (height_reg < c3n_pkg::HGT_W'(c3n_pkg::MIN_DIM))
                    ? c3n_pkg::HGT_W'(c3n_pkg::MIN_DIM)
                    : (height_reg > c3n_pkg::HGT_W'(c3n_pkg::MAX_HEIGHT))
                    ? c3n_pkg::HGT_W'(c3n_pkg::MAX_HEIGHT) : height_reg;
        geom.restart = cfg_we && (cfg.index == c3n_pkg::REG_WIDTH
                                  || cfg.index == c3n_pkg::REG_HEIGHT);
    end

    always_comb
    begin
        for (int k = 0; k < c3n_pkg::WIN_DIM; k++)
        begin
            kern.coef[k] = ktop_reg[k * c3n_pkg::CH_W +: c3n_pkg::CH_W];
            kern.coef[c3n_pkg::WIN_DIM + k] = kmid_reg[k * c3n_pkg::CH_W +: c3n_pkg::CH_W];
            kern.coef[2 * c3n_pkg::WIN_DIM + k] =
                kbot_reg[k * c3n_pkg::CH_W +: c3n_pkg::CH_W];
        end
        dsum = '0;
        for (int i = 0; i < c3n_pkg::TAPS; i++)
        begin
            dsum = dsum + c3n_pkg::DIV_W'($signed(kern.coef[i]));
        end
        kern.divisor = (dsum == '0) ? c3n_pkg::DIV_W'(1) : dsum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= c3n_pkg::WIDTH_RST;
            height_reg <= c3n_pkg::HEIGHT_RST;
            ktop_reg   <= c3n_pkg::KTOP_RST;
            kmid_reg   <= c3n_pkg::KMID_RST;
            kbot_reg   <= c3n_pkg::KBOT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg.index)
                c3n_pkg::REG_WIDTH:  width_reg  <= cfg.data[c3n_pkg::WID_W-1:0];
                c3n_pkg::REG_HEIGHT: height_reg <= cfg.data[c3n_pkg::HGT_W-1:0];
                c3n_pkg::REG_KTOP:   ktop_reg   <= cfg.data[c3n_pkg::KROW_W-1:0];
                c3n_pkg::REG_KMID:   kmid_reg   <= cfg.data[c3n_pkg::KROW_W-1:0];
                c3n_pkg::REG_KBOT:   kbot_reg   <= cfg.data[c3n_pkg::KROW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    c3n_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pixel_in),
        .geom     (geom),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    c3n_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    c3n_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_data     (q_out),
        .kern       (kern),
        .result_out (result_out)
    );

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("window pushed into a full queue");

    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from an empty queue");

    a_front_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_in.valid && pixel_in.ready) |=> !pixel_in.ready)
        else $error("front took a pixel while the previous one was still loading");

endmodule

>>> hw/rtl/c3n_queue.sv
`timescale 1ns / 1ps

module c3n_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  c3n_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output c3n_pkg::job_t pop_data,
    output logic          empty
);

    c3n_pkg::job_t                   entry_reg [c3n_pkg::QDEPTH];
    logic [c3n_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [c3n_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [c3n_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [c3n_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [c3n_pkg::QCNT_W-1:0]      cnt_reg;
    logic [c3n_pkg::QCNT_W-1:0]      cnt_next;

    assign full     = (cnt_reg == c3n_pkg::QCNT_W'(c3n_pkg::QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == c3n_pkg::QPTR_W'(c3n_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == c3n_pkg::QPTR_W'(c3n_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/c3n_front.sv
`timescale 1ns / 1ps

module c3n_front (
    input  logic           clk,
    input  logic           rst_n,
    c3n_pix_if.sink        pixel_in,
    input  c3n_pkg::geom_t geom,
    input  logic           q_full,
    output logic           q_push,
    output c3n_pkg::job_t  q_data
);

    c3n_pkg::front_state_t        state_reg;
    c3n_pkg::front_state_t        state_next;
    logic [c3n_pkg::COL_W-1:0]    col_reg;
    logic [c3n_pkg::COL_W-1:0]    col_next;
    logic [c3n_pkg::ROW_W-1:0]    row_reg;
    logic [c3n_pkg::ROW_W-1:0]    row_next;
    c3n_pkg::rgb_t                pix_reg;
    c3n_pkg::rgb_t                rd_a_reg;
    c3n_pkg::rgb_t                rd_b_reg;
    c3n_pkg::rgb_t [c3n_pkg::TAPS-1:0] win_reg;
    c3n_pkg::rgb_t [c3n_pkg::TAPS-1:0] win_next;

    c3n_pkg::rgb_t                line_a_mem [c3n_pkg::MAX_WIDTH];
    c3n_pkg::rgb_t                line_b_mem [c3n_pkg::MAX_WIDTH];

    logic accept;
    logic col_last;
    logic row_last;
    logic interior;

    assign pixel_in.ready = (state_reg == c3n_pkg::F_IDLE) && !q_full;
    assign accept         = pixel_in.valid && pixel_in.ready;

    assign col_last = (c3n_pkg::WID_W'(col_reg) + c3n_pkg::WID_W'(1)) >= geom.width;
    assign row_last = (c3n_pkg::HGT_W'(row_reg) + c3n_pkg::HGT_W'(1)) >= geom.height;
    assign interior = (col_reg >= c3n_pkg::COL_W'(c3n_pkg::WIN_DIM - 1))
                   && (row_reg >= c3n_pkg::ROW_W'(c3n_pkg::WIN_DIM - 1));

    assign q_data.win  = win_next;
    assign q_data.last = col_last && row_last;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        win_next   = win_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            c3n_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    state_next = c3n_pkg::F_LOAD;
                end
            end
            c3n_pkg::F_LOAD:
            begin
                // columns move left; top row is two lines back
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = rd_b_reg;
                win_next[3] = win_reg[4];
                win_next[4] = win_reg[5];
                win_next[5] = rd_a_reg;
                win_next[6] = win_reg[7];
                win_next[7] = win_reg[8];
                win_next[8] = pix_reg;
                q_push      = interior;
                if (col_last)
                begin
                    col_next = '0;
                    row_next = row_last ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                state_next = c3n_pkg::F_IDLE;
            end
            default:
            begin
                state_next = c3n_pkg::F_IDLE;
            end
        endcase
        if (geom.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c3n_pkg::F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            win_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            win_reg   <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= {pixel_in.blue, pixel_in.green, pixel_in.red};
            rd_a_reg <= line_a_mem[col_reg];
            rd_b_reg <= line_b_mem[col_reg];
        end
        if (state_reg == c3n_pkg::F_LOAD)
        begin
            line_a_mem[col_reg] <= pix_reg;
            line_b_mem[col_reg] <= rd_a_reg;
        end
    end

endmodule

>>> hw/rtl/c3n_back.sv
`timescale 1ns / 1ps

module c3n_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    output logic           q_pop,
    input  c3n_pkg::job_t  q_data,
    input  c3n_pkg::kern_t kern,
    c3n_res_if.source      result_out
);

    c3n_pkg::back_state_t              state_reg;
    c3n_pkg::back_state_t              state_next;
    c3n_pkg::job_t                     job_reg;
    c3n_pkg::job_t                     job_next;
    logic [c3n_pkg::TAP_W-1:0]         tap_reg;
    logic [c3n_pkg::TAP_W-1:0]         tap_next;
    logic [c3n_pkg::STEP_W-1:0]        step_reg;
    logic [c3n_pkg::STEP_W-1:0]        step_next;
    logic [c3n_pkg::DIV_W-2:0]         dabs_reg;
    logic [c3n_pkg::DIV_W-2:0]         dabs_next;
    logic                              dneg_reg;
    logic                              dneg_next;
    logic [c3n_pkg::REM_W-1:0]         dsh_reg;
    logic [c3n_pkg::REM_W-1:0]         dsh_next;
    logic signed [c3n_pkg::ACC_W-1:0]  acc_reg  [c3n_pkg::NUM_CH];
    logic signed [c3n_pkg::ACC_W-1:0]  acc_next [c3n_pkg::NUM_CH];
    logic [c3n_pkg::REM_W-1:0]         rem_reg  [c3n_pkg::NUM_CH];
    logic [c3n_pkg::REM_W-1:0]         rem_next [c3n_pkg::NUM_CH];
    logic [c3n_pkg::Q_W-1:0]           q_reg    [c3n_pkg::NUM_CH];
    logic [c3n_pkg::Q_W-1:0]           q_next   [c3n_pkg::NUM_CH];
    logic [c3n_pkg::NUM_CH-1:0]        sat_reg;
    logic [c3n_pkg::NUM_CH-1:0]        sat_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    c3n_pkg::rgb_t                     out_pix_reg;
    c3n_pkg::rgb_t                     out_pix_next;
    logic                              out_last_reg;
    logic                              out_last_next;

    logic signed [c3n_pkg::PROD_W-1:0] prod [c3n_pkg::NUM_CH];
    logic [c3n_pkg::REM_W-1:0]         mag  [c3n_pkg::NUM_CH];
    logic [c3n_pkg::NUM_CH-1:0]        same_sign;
    logic [c3n_pkg::REM_W-1:0]         dlim;

    assign result_out.valid      = out_valid_reg;
    assign result_out.out_red    = out_pix_reg[0 +: c3n_pkg::CH_W];
    assign result_out.out_green  = out_pix_reg[c3n_pkg::CH_W +: c3n_pkg::CH_W];
    assign result_out.out_blue   = out_pix_reg[2 * c3n_pkg::CH_W +: c3n_pkg::CH_W];
    assign result_out.frame_last = out_last_reg;

    assign dlim = c3n_pkg::REM_W'(dabs_reg) << c3n_pkg::Q_W;

    always_comb
    begin
        for (int c = 0; c < c3n_pkg::NUM_CH; c++)
        begin
            prod[c] = $signed({1'b0, job_reg.win[tap_reg][c * c3n_pkg::CH_W +: c3n_pkg::CH_W]})
                    * $signed(kern.coef[tap_reg]);
            mag[c] = acc_reg[c][c3n_pkg::ACC_W-1] ? c3n_pkg::REM_W'(-acc_reg[c])
                                                  : c3n_pkg::REM_W'(acc_reg[c]);
            same_sign[c] = (acc_reg[c][c3n_pkg::ACC_W-1] == dneg_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        tap_next       = tap_reg;
        step_next      = step_reg;
        dabs_next      = dabs_reg;
        dneg_next      = dneg_reg;
        dsh_next       = dsh_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_pix_next   = out_pix_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            c3n_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    job_next  = q_data;
                    tap_next  = '0;
                    dneg_next = kern.divisor[c3n_pkg::DIV_W-1];
                    dabs_next = kern.divisor[c3n_pkg::DIV_W-1]
                              ? (c3n_pkg::DIV_W-1)'(-kern.divisor)
                              : (c3n_pkg::DIV_W-1)'(kern.divisor);
                    for (int c = 0; c < c3n_pkg::NUM_CH; c++)
                    begin
                        acc_next[c] = '0;
                    end
                    state_next = c3n_pkg::B_MAC;
                end
            end
            c3n_pkg::B_MAC:
            begin
                for (int c = 0; c < c3n_pkg::NUM_CH; c++)
                begin
                    acc_next[c] = acc_reg[c] + c3n_pkg::ACC_W'(prod[c]);
                end
                tap_next = tap_reg + 1'b1;
                if (tap_reg == c3n_pkg::TAP_W'(c3n_pkg::TAPS - 1))
                begin
                    state_next = c3n_pkg::B_SETUP;
                end
            end
            c3n_pkg::B_SETUP:
            begin
                // opposite signs clamp the result to zero
                for (int c = 0; c < c3n_pkg::NUM_CH; c++)
                begin
                    rem_next[c] = same_sign[c] ? mag[c] : '0;
                    sat_next[c] = same_sign[c] && (mag[c] >= dlim);
                    q_next[c]   = '0;
                end
                dsh_next   = c3n_pkg::REM_W'(dabs_reg) << (c3n_pkg::Q_W - 1);
                step_next  = '0;
                state_next = c3n_pkg::B_DIV;
            end
            c3n_pkg::B_DIV:
            begin
                for (int c = 0; c < c3n_pkg::NUM_CH; c++)
                begin
                    if (rem_reg[c] >= dsh_reg)
                    begin
                        rem_next[c] = rem_reg[c] - dsh_reg;
                        q_next[c]   = {q_reg[c][c3n_pkg::Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q_next[c] = {q_reg[c][c3n_pkg::Q_W-2:0], 1'b0};
                    end
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == c3n_pkg::STEP_W'(c3n_pkg::Q_W - 1))
                begin
                    state_next = c3n_pkg::B_DONE;
                end
            end
            c3n_pkg::B_DONE:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = job_reg.last;
                    for (int c = 0; c < c3n_pkg::NUM_CH; c++)
                    begin
                        out_pix_next[c * c3n_pkg::CH_W +: c3n_pkg::CH_W] =
                            sat_reg[c] ? '1 : q_reg[c];
                    end
                    state_next = c3n_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = c3n_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= c3n_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        tap_reg      <= tap_next;
        step_reg     <= step_next;
        dabs_reg     <= dabs_next;
        dneg_reg     <= dneg_next;
        dsh_reg      <= dsh_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        sat_reg      <= sat_next;
        out_pix_reg  <= out_pix_next;
        out_last_reg <= out_last_next;
    end

endmodule
